[rtl/uoc_pkg.sv]
// ----------------------------------------------------------------------------
// uoc_pkg: shared types and constants of the uniform and order crossover
// Widths, depths and the beat formats passed between the front part, the
// item queue and the back part.
// ----------------------------------------------------------------------------
package uoc_pkg;

    localparam int MAX_POS   = 64;
    localparam int POS_W     = $clog2(MAX_POS);
    localparam int CNT_W     = POS_W + 1;
    localparam int VEH_W     = 8;
    localparam int ORD_W     = 7;
    localparam int CUT_W     = 6;
    localparam int TRUCK_W   = 8;
    localparam int Q_DEPTH   = 2;
    localparam int OQ_DEPTH  = 2;

    localparam logic [TRUCK_W-1:0] TRUCK_RESET = TRUCK_W'(1);

    // One classified input position, as queued between front and back.
    typedef struct packed {
        logic [VEH_W-1:0] vehicle;
        logic [ORD_W-1:0] order1;
        logic [ORD_W-1:0] order2;
        logic [CUT_W-1:0] cut_start;
        logic [CUT_W-1:0] cut_end;
        logic             last;
    } t_item;

    // One child position on its way out.
    typedef struct packed {
        logic [VEH_W-1:0] vehicle;
        logic [ORD_W-1:0] order;
        logic [POS_W-1:0] position;
        logic             final_pos;
    } t_result;

endpackage

[rtl/uoc_front.sv]
// ----------------------------------------------------------------------------
// uoc_front: input classification
// Holds the truck count register and picks the child vehicle gene of each
// incoming position by uniform crossover with the truck repair rule.
// ----------------------------------------------------------------------------
module uoc_front
    import uoc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [TRUCK_W-1:0] i_cfg_wdata,
    input  logic [VEH_W-1:0]   i_parent1_vehicle,
    input  logic [VEH_W-1:0]   i_parent2_vehicle,
    input  logic [ORD_W-1:0]   i_parent1_order,
    input  logic [ORD_W-1:0]   i_parent2_order,
    input  logic               i_staff_only,
    input  logic               i_pick_second,
    input  logic [CUT_W-1:0]   i_cut_start,
    input  logic [CUT_W-1:0]   i_cut_end,
    input  logic               i_last_position,
    output t_item              o_item
);

    logic [TRUCK_W-1:0] r_truck_count;
    logic [VEH_W-1:0]   got;
    logic [VEH_W-1:0]   other;
    logic [VEH_W-1:0]   picked;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_truck_count <= TRUCK_RESET;
        end else if (i_cfg_we) begin
            r_truck_count <= i_cfg_wdata;
        end
    end

    // A truck-only position falls back to the other parent, then to parent one.
    always_comb begin
        got   = i_pick_second ? i_parent2_vehicle : i_parent1_vehicle;
        other = i_pick_second ? i_parent1_vehicle : i_parent2_vehicle;
        if (!i_staff_only || got <= r_truck_count) begin
            picked = got;
        end else if (other <= r_truck_count) begin
            picked = other;
        end else begin
            picked = i_parent1_vehicle;
        end
    end

    assign o_item.vehicle   = picked;
    assign o_item.order1    = i_parent1_order;
    assign o_item.order2    = i_parent2_order;
    assign o_item.cut_start = i_cut_start;
    assign o_item.cut_end   = i_cut_end;
    assign o_item.last      = i_last_position;

endmodule

[rtl/uoc_queue.sv]
// ----------------------------------------------------------------------------
// uoc_queue: item queue between front and back
// A short register queue so that the front keeps taking beats while the back
// part is busy.
// ----------------------------------------------------------------------------
module uoc_queue
    import uoc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_data
);

    localparam int QP_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

    t_item             r_mem [Q_DEPTH];
    logic [QP_W-1:0]   r_wp;
    logic [QP_W-1:0]   r_rp;
    logic [QP_W:0]     r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == (QP_W+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == QP_W'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == QP_W'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

[rtl/uoc_back.sv]
// ----------------------------------------------------------------------------
// uoc_back: chromosome stores, order crossover sequencer and result queue
// Stores each position, runs OX1 over the stores after the last position and
// streams the child out through a two-entry result queue.
// ----------------------------------------------------------------------------
module uoc_back
    import uoc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_item   i_q_data,
    output logic    o_q_pop,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_result
);

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_MRD  = 3'd1;
    localparam logic [2:0] S_MMK  = 3'd2;
    localparam logic [2:0] S_FRD  = 3'd3;
    localparam logic [2:0] S_FWR  = 3'd4;
    localparam logic [2:0] S_ERD  = 3'd5;
    localparam logic [2:0] S_EWR  = 3'd6;

    localparam int OP_W = (OQ_DEPTH > 1) ? $clog2(OQ_DEPTH) : 1;

    logic [VEH_W-1:0] m_veh [MAX_POS];
    logic [ORD_W-1:0] m_o1  [MAX_POS];
    logic [ORD_W-1:0] m_o2  [MAX_POS];
    logic [ORD_W-1:0] m_co  [MAX_POS];

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_loaded, n_loaded;
    logic [CNT_W-1:0] r_count, n_count;
    logic [POS_W-1:0] r_e, n_e;
    logic [POS_W-1:0] r_ptr, n_ptr;
    logic [POS_W-1:0] r_rdidx, n_rdidx;
    logic [POS_W-1:0] r_slot, n_slot;
    logic [POS_W-1:0] r_i, n_i;
    logic [MAX_POS:0] r_used, n_used;
    logic [ORD_W-1:0] r_rd1, r_rd2, r_eo;
    logic [VEH_W-1:0] r_ev;

    t_result          r_oq [OQ_DEPTH];
    logic [OP_W-1:0]  r_owp, r_orp;
    logic [OP_W:0]    r_ocnt;

    logic [CNT_W-1:0] ld_cnt;
    logic [POS_W-1:0] cm1, cs_c, ce_c, s_c, e_c;
    logic [POS_W-1:0] cnt_m1;
    logic [POS_W-1:0] e_wrap;
    logic [CNT_W-1:0] e_plus;
    logic             ld_wr;
    logic             co_we;
    logic [POS_W-1:0] co_addr;
    logic [ORD_W-1:0] co_data;
    logic             gene_used;
    logic             o_push;
    logic             o_pop;
    t_result          o_new;

    // Cut handling for the run that the last beat starts.
    always_comb begin
        ld_cnt = (r_loaded < CNT_W'(MAX_POS)) ? r_loaded + 1'b1 : CNT_W'(MAX_POS);
        cm1    = POS_W'(ld_cnt - 1'b1);
        cs_c   = (i_q_data.cut_start > cm1) ? cm1 : i_q_data.cut_start;
        ce_c   = (i_q_data.cut_end > cm1) ? cm1 : i_q_data.cut_end;
        s_c    = (cs_c > ce_c) ? ce_c : cs_c;
        e_c    = (cs_c > ce_c) ? cs_c : ce_c;
    end

    assign cnt_m1    = POS_W'(r_count - 1'b1);
    assign e_plus    = CNT_W'(r_e) + 1'b1;
    assign e_wrap    = (e_plus == r_count) ? '0 : POS_W'(e_plus);
    assign gene_used = (r_rd2 <= ORD_W'(MAX_POS)) ? r_used[r_rd2] : 1'b0;
    assign o_q_pop   = (r_state == S_LOAD) && i_q_valid;
    assign ld_wr     = o_q_pop && (r_loaded < CNT_W'(MAX_POS));

    always_comb begin
        n_state  = r_state;
        n_loaded = r_loaded;
        n_count  = r_count;
        n_e      = r_e;
        n_ptr    = r_ptr;
        n_rdidx  = r_rdidx;
        n_slot   = r_slot;
        n_i      = r_i;
        n_used   = r_used;
        co_we    = 1'b0;
        co_addr  = r_slot;
        co_data  = r_rd2;
        o_push   = 1'b0;
        case (r_state)
            S_LOAD: begin
                if (o_q_pop) begin
                    // Loading also seeds the child order with parent one.
                    if (ld_wr) begin
                        co_we    = 1'b1;
                        co_addr  = POS_W'(r_loaded);
                        co_data  = i_q_data.order1;
                        n_loaded = r_loaded + 1'b1;
                    end
                    if (i_q_data.last) begin
                        n_loaded = '0;
                        n_count  = ld_cnt;
                        n_e      = e_c;
                        n_ptr    = s_c;
                        n_used   = '0;
                        n_state  = S_MRD;
                    end
                end
            end
            S_MRD: begin
                n_state = S_MMK;
            end
            S_MMK: begin
                if (r_rd1 <= ORD_W'(MAX_POS)) begin
                    n_used[r_rd1] = 1'b1;
                end
                if (r_ptr == r_e) begin
                    n_rdidx = e_wrap;
                    n_slot  = e_wrap;
                    n_i     = '0;
                    n_state = S_FRD;
                end else begin
                    n_ptr   = r_ptr + 1'b1;
                    n_state = S_MRD;
                end
            end
            S_FRD: begin
                n_state = S_FWR;
            end
            S_FWR: begin
                if (!gene_used) begin
                    co_we  = 1'b1;
                    n_slot = (r_slot == cnt_m1) ? '0 : r_slot + 1'b1;
                end
                n_rdidx = (r_rdidx == cnt_m1) ? '0 : r_rdidx + 1'b1;
                if (r_i == cnt_m1) begin
                    n_ptr   = '0;
                    n_state = S_ERD;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_FRD;
                end
            end
            S_ERD: begin
                if (r_ocnt != (OP_W+1)'(OQ_DEPTH)) begin
                    n_state = S_EWR;
                end
            end
            S_EWR: begin
                o_push = 1'b1;
                if (r_ptr == cnt_m1) begin
                    n_state = S_LOAD;
                end else begin
                    n_ptr   = r_ptr + 1'b1;
                    n_state = S_ERD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ld_wr) begin
            m_veh[POS_W'(r_loaded)] <= i_q_data.vehicle;
            m_o1[POS_W'(r_loaded)]  <= i_q_data.order1;
            m_o2[POS_W'(r_loaded)]  <= i_q_data.order2;
        end
        if (co_we) begin
            m_co[co_addr] <= co_data;
        end
        r_rd1 <= m_o1[r_ptr];
        r_rd2 <= m_o2[r_rdidx];
        r_ev  <= m_veh[r_ptr];
        r_eo  <= m_co[r_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_loaded <= '0;
            r_count  <= '0;
            r_used   <= '0;
        end else begin
            r_state  <= n_state;
            r_loaded <= n_loaded;
            r_count  <= n_count;
            r_used   <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e     <= n_e;
        r_ptr   <= n_ptr;
        r_rdidx <= n_rdidx;
        r_slot  <= n_slot;
        r_i     <= n_i;
    end

    // Result queue.
    assign o_new.vehicle   = r_ev;
    assign o_new.order     = r_eo;
    assign o_new.position  = r_ptr;
    assign o_new.final_pos = (r_ptr == cnt_m1);
    assign o_empty         = (r_ocnt == '0);
    assign o_pop           = i_pop && !o_empty;
    assign o_result        = r_oq[r_orp];

    always_ff @(posedge i_clk) begin
        if (o_push) begin
            r_oq[r_owp] <= o_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= '0;
            r_orp  <= '0;
            r_ocnt <= '0;
        end else begin
            if (o_push) begin
                r_owp <= (r_owp == OP_W'(OQ_DEPTH - 1)) ? '0 : r_owp + 1'b1;
            end
            if (o_pop) begin
                r_orp <= (r_orp == OP_W'(OQ_DEPTH - 1)) ? '0 : r_orp + 1'b1;
            end
            if (o_push && !o_pop) begin
                r_ocnt <= r_ocnt + 1'b1;
            end else if (o_pop && !o_push) begin
                r_ocnt <= r_ocnt - 1'b1;
            end
        end
    end

    // The result queue never overflows: emission waits for room.
    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt <= (OP_W+1)'(OQ_DEPTH))
        else $error("result queue overflow");

    // Fill indices stay inside the loaded positions.
    a_fill_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FWR) |-> (CNT_W'(r_slot) < r_count && CNT_W'(r_rdidx) < r_count))
        else $error("fill index beyond loaded count");

    // The last emitted position hands the block back to loading.
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EWR && r_ptr == cnt_m1) |=> (r_state == S_LOAD))
        else $error("run did not end after final position");

    // No new beat is taken from the queue while a run is in flight.
    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> !o_q_pop)
        else $error("queue popped during a crossover run");

endmodule

[rtl/uniform_and_order_crossover.sv]
// ----------------------------------------------------------------------------
// uniform_and_order_crossover: uniform crossover on vehicles, OX1 on order
// Loads two parent chromosomes one position per beat and emits the child
// chromosome one position per beat once the last position has arrived.
//
//   Channel   Handshake            Payload
//   -------   ------------------   ----------------------------------------
//   input     push / full          parent genes, staff flag, pick bit, cuts,
//                                  last-position mark
//   result    empty / pop          child vehicle, child order, position,
//                                  final-position mark
//   config    i_cfg_we             i_cfg_wdata = truck count (reset 1)
//
// Beats are taken only in the load state. The last beat starts a run
// that marks each copied-segment position (read, then mark), fills each loaded
// position from parent two (read, then write) and emits each loaded position
// (read, then write); reads go through each store's single read port.
// During a run the two-entry item queue absorbs new beats and then raises full.
// A stalled result side holds the emission sequencer; nothing is lost.
// Synchronous reset clears the load count, sequencer, queues, used marks and
// sets the truck count to one; the chromosome stores are not cleared.
// ----------------------------------------------------------------------------
module uniform_and_order_crossover
    import uoc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration
    input  logic               i_cfg_we,
    input  logic [TRUCK_W-1:0] i_cfg_wdata,
    // Input beats
    input  logic               push,
    output logic               full,
    input  logic [VEH_W-1:0]   i_parent1_vehicle,
    input  logic [VEH_W-1:0]   i_parent2_vehicle,
    input  logic [ORD_W-1:0]   i_parent1_order,
    input  logic [ORD_W-1:0]   i_parent2_order,
    input  logic               i_staff_only,
    input  logic               i_pick_second,
    input  logic [CUT_W-1:0]   i_cut_start,
    input  logic [CUT_W-1:0]   i_cut_end,
    input  logic               i_last_position,
    // Result beats
    output logic               empty,
    input  logic               pop,
    output logic [VEH_W-1:0]   o_child_vehicle,
    output logic [ORD_W-1:0]   o_child_order,
    output logic [POS_W-1:0]   o_position,
    output logic               o_final_position
);

    t_item   front_item;
    t_item   q_item;
    logic    q_valid;
    logic    q_pop;
    t_result result;

    // The front classifies every beat as it arrives; the vehicle choice needs
    // only the current truck count, so it is settled before queuing.
    uoc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_parent1_vehicle (i_parent1_vehicle),
        .i_parent2_vehicle (i_parent2_vehicle),
        .i_parent1_order   (i_parent1_order),
        .i_parent2_order   (i_parent2_order),
        .i_staff_only      (i_staff_only),
        .i_pick_second     (i_pick_second),
        .i_cut_start       (i_cut_start),
        .i_cut_end         (i_cut_end),
        .i_last_position   (i_last_position),
        .o_item            (front_item)
    );

    // The queue decouples acceptance from the crossover run.
    uoc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_item),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_item)
    );

    // The back part owns the stores, the OX1 sequencer and the result queue.
    uoc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_item),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (result)
    );

    assign o_child_vehicle  = result.vehicle;
    assign o_child_order    = result.order;
    assign o_position       = result.position;
    assign o_final_position = result.final_pos;

endmodule
